FILE: hdl/wmm_pkg.sv
// Package for the window median/min/max block: widths, FSM state and cell control types.
package wmm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 4;
    localparam int OUT_W    = 56;

    typedef enum logic [0:0] {
        ST_LOAD,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

FILE: hdl/wmm_cell.sv
// One insertion-sort cell: holds a sample, inserts by neighbor compare, shifts down on drain.
module wmm_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wmm_pkg::cell_ctrl_t               ctrl,
    input  logic [wmm_pkg::SAMPLE_W-1:0]      sample,
    input  logic [wmm_pkg::SAMPLE_W-1:0]      left_val,
    input  logic                              left_gt,
    input  logic                              left_valid,
    input  logic [wmm_pkg::SAMPLE_W-1:0]      right_val,
    output logic [wmm_pkg::SAMPLE_W-1:0]      val,
    output logic                              valid,
    output logic                              gt
);

    logic [wmm_pkg::SAMPLE_W-1:0] val_reg;
    logic [wmm_pkg::SAMPLE_W-1:0] val_next;
    logic                         valid_reg;
    logic                         valid_next;

    assign gt    = valid_reg && (val_reg > sample);
    assign val   = val_reg;
    assign valid = valid_reg;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            val_next = right_val;
        end
        else if (ctrl.insert)
        begin
            if (left_gt)
            begin
                val_next   = left_val;
                valid_next = 1'b1;
            end
            // only the first empty cell takes a sample that belongs at the end
            else if (gt || (!valid_reg && left_valid))
            begin
                val_next   = sample;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

FILE: hdl/wmm_chain.sv
// Row of sort cells keeping the window in ascending order, lowest value at cell 0.
module wmm_chain #(
    parameter int DEPTH = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  wmm_pkg::cell_ctrl_t               ctrl,
    input  logic [wmm_pkg::SAMPLE_W-1:0]      sample,
    output logic [wmm_pkg::SAMPLE_W-1:0]      head0,
    output logic [wmm_pkg::SAMPLE_W-1:0]      head1,
    output logic [DEPTH-1:0]                  valid_vec
);

    logic [wmm_pkg::SAMPLE_W-1:0] val [DEPTH];
    logic [DEPTH-1:0]             gt;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [wmm_pkg::SAMPLE_W-1:0] lv;
            logic                         lg;
            logic                         lvld;
            logic [wmm_pkg::SAMPLE_W-1:0] rv;

            if (i == 0)
            begin : g_first
                assign lv   = '0;
                assign lg   = 1'b0;
                assign lvld = 1'b1;
            end
            else
            begin : g_mid
                assign lv   = val[i-1];
                assign lg   = gt[i-1];
                assign lvld = valid_vec[i-1];
            end

            if (i == DEPTH-1)
            begin : g_end
                assign rv = '0;
            end
            else
            begin : g_inner
                assign rv = val[i+1];
            end

            wmm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .sample     (sample),
                .left_val   (lv),
                .left_gt    (lg),
                .left_valid (lvld),
                .right_val  (rv),
                .val        (val[i]),
                .valid      (valid_vec[i]),
                .gt         (gt[i])
            );
        end
    endgenerate

    assign head0 = val[0];
    assign head1 = val[1];

endmodule

FILE: hdl/window_median_min_max_top.sv
// Top level: window statistics (median, min/max with positions) over a sort-cell chain.
// Non-closing beats: accepted one per cycle while s_tready is high, no result.
// Closing beat (tlast) of n samples: the chain shifts down until the median sits in cell 0
// (cells 0 and 1 for even n), then the result registers once the master side is free;
// s_tready stays low until the result registers. Next window flows while a result waits.
// Reset: async active low; clears fill count, cell valid bits, FSM and output valid.
module window_median_min_max_top #(
    parameter int WINDOW = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // sample[15:0]
    input  logic                          s_tlast,   // last sample of window
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wmm_pkg::OUT_W-1:0]     m_tdata    // median[15:0], min_sample[31:16],
                                                     // min_position[35:32], max_sample[51:36],
                                                     // max_position[55:52]
);

    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SW    = wmm_pkg::SAMPLE_W;
    localparam int PW    = wmm_pkg::POS_W;

    wmm_pkg::state_t      state_reg, state_next;
    wmm_pkg::cell_ctrl_t  ctrl;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             odd_reg, odd_next;
    logic [SW-1:0]    min_reg, min_next, max_reg, max_next;
    logic [PW-1:0]    minpos_reg, minpos_next, maxpos_reg, maxpos_next;
    logic             out_valid_reg, out_valid_next;
    logic [wmm_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic [SW-1:0]     head0, head1;
    logic [WINDOW-1:0] valid_vec;
    logic              accept, take, finish;
    logic [CNT_W-1:0]  n_close;
    logic [SW:0]       pair_sum;
    logic [SW-1:0]     median;

    assign s_tready = (state_reg == wmm_pkg::ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign take     = accept && (count_reg < CNT_W'(WINDOW));
    assign n_close  = count_reg + CNT_W'(take);
    assign finish   = (state_reg == wmm_pkg::ST_SHIFT) && (remain_reg == '0)
                      && (!out_valid_reg || m_tready);

    assign ctrl.insert = take;
    assign ctrl.shift  = (state_reg == wmm_pkg::ST_SHIFT) && (remain_reg != '0);
    assign ctrl.clear  = finish;

    assign pair_sum = {1'b0, head0} + {1'b0, head1};
    assign median   = odd_reg ? head0 : pair_sum[SW:1];

    wmm_chain #(
        .DEPTH (WINDOW)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .sample    (s_tdata),
        .head0     (head0),
        .head1     (head1),
        .valid_vec (valid_vec)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        remain_next    = remain_reg;
        odd_next       = odd_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        minpos_next    = minpos_reg;
        maxpos_next    = maxpos_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            wmm_pkg::ST_LOAD:
            begin
                if (take)
                begin
                    count_next = n_close;
                    if ((count_reg == '0) || (s_tdata <= min_reg))
                    begin
                        min_next    = s_tdata;
                        minpos_next = PW'(count_reg);
                    end
                    if ((count_reg == '0) || (s_tdata >= max_reg))
                    begin
                        max_next    = s_tdata;
                        maxpos_next = PW'(count_reg);
                    end
                end
                if (accept && s_tlast)
                begin
                    remain_next = (n_close - CNT_W'(1)) >> 1;
                    odd_next    = n_close[0];
                    state_next  = wmm_pkg::ST_SHIFT;
                end
            end
            wmm_pkg::ST_SHIFT:
            begin
                if (remain_reg != '0)
                begin
                    remain_next = remain_reg - CNT_W'(1);
                end
                else if (finish)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {maxpos_reg, max_reg, minpos_reg, min_reg, median};
                    count_next     = '0;
                    state_next     = wmm_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = wmm_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wmm_pkg::ST_LOAD;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        odd_reg      <= odd_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        minpos_reg   <= minpos_next;
        maxpos_reg   <= maxpos_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WINDOW))
        else $error("fill count above window depth");

    a_cells_match_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wmm_pkg::ST_LOAD) |-> ($countones(valid_vec) == int'(count_reg)))
        else $error("occupied cells differ from fill count");

    a_close_to_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> (state_reg == wmm_pkg::ST_SHIFT))
        else $error("closing beat did not start drain");

    a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> (m_tvalid && (count_reg == '0) && (valid_vec == '0)))
        else $error("window close did not emit and clear");
`endif

endmodule
